// File: rtl/lcr_pkg.sv
package lcr_pkg;

  // Command codes carried by the command field of an input item.
  typedef enum logic [2:0] {
    CMD_SCAN       = 3'd0,
    CMD_INSERT     = 3'd1,
    CMD_DROP_FLOOR = 3'd2,
    CMD_DROP_ALL   = 3'd3,
    CMD_NEXT_FLOOR = 3'd4,
    CMD_SET_ENABLE = 3'd5
  } cmd_e;

  // Register indexes on the configuration port (byte address 4*index).
  typedef enum logic [1:0] {
    REG_TOP_FLOOR       = 2'd0,
    REG_PARKING_TICKS   = 2'd1,
    REG_PARK_FLOOR      = 2'd2,
    REG_FULL_COLLECTIVE = 2'd3
  } reg_idx_e;

  localparam logic [4:0]  TOP_FLOOR_RST       = 5'd7;
  localparam logic [15:0] PARKING_TICKS_RST   = 16'd0;
  localparam logic [4:0]  PARK_FLOOR_RST      = 5'd0;
  localparam logic        FULL_COLLECTIVE_RST = 1'b0;

  typedef struct packed {
    logic [4:0]  top_floor;
    logic [15:0] parking_ticks;
    logic [4:0]  park_floor;
    logic        full_collective;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic step;  // execute the accepted item and load its result
  } ctrl_t;

endpackage

// File: rtl/lift_call_register_core.sv
// Lift call register: per-floor car, down and up hall call masks with
// parking timer and scan enable.
//
// Input channel (in_valid_i / in_stall_o): one command item per transfer,
// taken when valid is high and stall is low. Output channel (out_valid_o /
// out_stall_i): exactly one result item per command, holding the call
// masks after the command plus pending, reopen and light flags.
//
// Latency: the result is valid the cycle after its item is accepted.
// Throughput: one item per cycle while the receiver takes results; all
// per-floor work is parallel mask logic in a single register stage. The
// result register is the only buffer, so a stalled result stalls the
// input until it is taken; a stalled result holds its value.
//
// Reset (rst_ni low, asynchronous) clears all call masks, the idle counter
// and the scan enable, and loads register defaults (top floor 7, parking off).
// Configuration must be written over the APB port only while idle (unchecked).
module lift_call_register_core
  import lcr_pkg::*;
#(
  parameter int FLOORS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input item
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        command_i,
  input  logic [4:0]        floor_i,
  input  logic [4:0]        current_floor_i,
  input  logic [FLOORS-1:0] car_buttons_i,
  input  logic [FLOORS-1:0] down_buttons_i,
  input  logic [FLOORS-1:0] up_buttons_i,
  input  logic              service_off_i,
  input  logic              moving_up_i,
  input  logic              in_floor_zone_i,
  input  logic              car_idle_i,
  input  logic              high_speed_i,
  input  logic              enable_value_i,
  // result item
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [FLOORS-1:0] car_calls_o,
  output logic [FLOORS-1:0] down_calls_o,
  output logic [FLOORS-1:0] up_calls_o,
  output logic              calls_pending_o,
  output logic              reopen_door_o,
  output logic              light_reset_o
);

  cfg_t  cfg;
  ctrl_t ctrl;

  // Register file for the four configuration registers.
  lcr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake controller: accepts items and holds each result until taken.
  lcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  // Call masks, parking counter and command decode.
  lcr_datapath #(
    .FLOORS (FLOORS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cfg_i           (cfg),
    .command_i       (command_i),
    .floor_i         (floor_i),
    .current_floor_i (current_floor_i),
    .car_buttons_i   (car_buttons_i),
    .down_buttons_i  (down_buttons_i),
    .up_buttons_i    (up_buttons_i),
    .service_off_i   (service_off_i),
    .moving_up_i     (moving_up_i),
    .in_floor_zone_i (in_floor_zone_i),
    .car_idle_i      (car_idle_i),
    .high_speed_i    (high_speed_i),
    .enable_value_i  (enable_value_i),
    .car_calls_o     (car_calls_o),
    .down_calls_o    (down_calls_o),
    .up_calls_o      (up_calls_o),
    .calls_pending_o (calls_pending_o),
    .reopen_door_o   (reopen_door_o),
    .light_reset_o   (light_reset_o)
  );

endmodule

// File: rtl/lcr_regs.sv
module lcr_regs
  import lcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_TOP_FLOOR:       cfg_d.top_floor       = pwdata[4:0];
        REG_PARKING_TICKS:   cfg_d.parking_ticks   = pwdata[15:0];
        REG_PARK_FLOOR:      cfg_d.park_floor      = pwdata[4:0];
        REG_FULL_COLLECTIVE: cfg_d.full_collective = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TOP_FLOOR:       prdata = {27'd0, cfg_q.top_floor};
      REG_PARKING_TICKS:   prdata = {16'd0, cfg_q.parking_ticks};
      REG_PARK_FLOOR:      prdata = {27'd0, cfg_q.park_floor};
      REG_FULL_COLLECTIVE: prdata = {31'd0, cfg_q.full_collective};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.top_floor       <= TOP_FLOOR_RST;
      cfg_q.parking_ticks   <= PARKING_TICKS_RST;
      cfg_q.park_floor      <= PARK_FLOOR_RST;
      cfg_q.full_collective <= FULL_COLLECTIVE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/lcr_ctrl.sv
module lcr_ctrl
  import lcr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_HOLD;
      ST_HOLD: if (!out_stall_i && !accept) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // A held result blocks new items only while the receiver stalls it.
  always_comb begin
    in_stall_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: ;
      ST_HOLD: begin
        out_valid_o = 1'b1;
        in_stall_o  = out_stall_i;
      end
      default: ;
    endcase
    ctrl_o.step = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.step |=> out_valid_o)
    else $error("accepted item produced no result");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !ctrl_o.step)
    else $error("item accepted over a stalled result");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctrl_o.step))
    else $error("result shown without an accepted item");
`endif

endmodule

// File: rtl/lcr_datapath.sv
module lcr_datapath
  import lcr_pkg::*;
#(
  parameter int FLOORS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  input  cfg_t              cfg_i,
  input  logic [2:0]        command_i,
  input  logic [4:0]        floor_i,
  input  logic [4:0]        current_floor_i,
  input  logic [FLOORS-1:0] car_buttons_i,
  input  logic [FLOORS-1:0] down_buttons_i,
  input  logic [FLOORS-1:0] up_buttons_i,
  input  logic              service_off_i,
  input  logic              moving_up_i,
  input  logic              in_floor_zone_i,
  input  logic              car_idle_i,
  input  logic              high_speed_i,
  input  logic              enable_value_i,
  output logic [FLOORS-1:0] car_calls_o,
  output logic [FLOORS-1:0] down_calls_o,
  output logic [FLOORS-1:0] up_calls_o,
  output logic              calls_pending_o,
  output logic              reopen_door_o,
  output logic              light_reset_o
);

  // Floors at or above FLOORS give an empty mask.
  function automatic logic [FLOORS-1:0] floor_bit(input logic [4:0] f);
    logic [FLOORS-1:0] r;
    for (int i = 0; i < FLOORS; i++) r[i] = (f == 5'(i));
    return r;
  endfunction

  logic [FLOORS-1:0] car_q, car_d, down_q, down_d, up_q, up_d;
  logic [15:0]       idle_q, idle_d;
  logic              en_q, en_d;
  logic              reopen_q, reopen_d, light_q, light_d;

  logic [FLOORS-1:0] served, above, below, here, fb;
  logic [FLOORS-1:0] c, d, u, dblock, ublock, rest;
  logic [15:0]       cnt1;
  logic [4:0]        nxt;
  cmd_e              cmd;

  assign cmd  = cmd_e'(command_i);
  assign here = floor_bit(current_floor_i);
  assign fb   = floor_bit(floor_i);
  assign cnt1 = idle_q + 16'd1;

  always_comb begin
    for (int i = 0; i < FLOORS; i++) begin
      served[i] = (5'(i) <= cfg_i.top_floor);
      above[i]  = (5'(i) > floor_i);
      below[i]  = (5'(i) < floor_i);
    end
  end

  always_comb begin
    car_d    = car_q;
    down_d   = down_q;
    up_d     = up_q;
    idle_d   = idle_q;
    en_d     = en_q;
    reopen_d = 1'b0;
    light_d  = 1'b0;
    c        = car_buttons_i & served;
    d        = down_buttons_i & served;
    u        = cfg_i.full_collective ? (up_buttons_i & served) : '0;
    dblock   = here | floor_bit(5'd0);
    ublock   = here | floor_bit(cfg_i.top_floor);
    rest     = '0;
    nxt      = current_floor_i;
    case (cmd)
      CMD_SCAN: begin
        light_d = (|(car_q | down_q | up_q)) | (!service_off_i && (|(c | d | u)));
        if (!service_off_i && en_q) begin
          car_d = car_q | (c & ~here);
          if (!cfg_i.full_collective) begin
            down_d   = down_q | (d & ~here);
            reopen_d = |(d & here);
          end else begin
            down_d   = down_q | (d & ~dblock);
            up_d     = up_q | (u & ~ublock);
            reopen_d = (|(d & dblock)) | (|(u & ublock));
          end
          // Parking timer looks at the masks after this scan.
          if (cfg_i.parking_ticks != 16'd0) begin
            if (|(car_d | down_d | up_d)) begin
              idle_d = 16'd0;
            end else if (cnt1 >= cfg_i.parking_ticks) begin
              idle_d = 16'd0;
              if (current_floor_i != cfg_i.park_floor &&
                  cfg_i.park_floor <= cfg_i.top_floor && car_idle_i) begin
                car_d = car_d | floor_bit(cfg_i.park_floor);
              end
            end else begin
              idle_d = cnt1;
            end
          end
        end
      end
      CMD_INSERT: begin
        if (current_floor_i != floor_i && floor_i <= cfg_i.top_floor) car_d = car_q | fb;
      end
      CMD_DROP_FLOOR: begin
        car_d = car_q & ~fb;
        if (floor_i == cfg_i.top_floor || floor_i == 5'd0 || !cfg_i.full_collective) begin
          down_d = down_q & ~fb;
          up_d   = up_q & ~fb;
        end else if (moving_up_i) begin
          rest = (car_d | down_q | up_q) & above;
          up_d = up_q & ~fb;
          if (rest == '0) down_d = down_q & ~fb;
        end else begin
          rest   = (car_d | down_q | up_q) & below;
          down_d = down_q & ~fb;
          if (rest == '0) up_d = up_q & ~fb;
        end
      end
      CMD_DROP_ALL: begin
        car_d  = '0;
        down_d = '0;
        up_d   = '0;
      end
      CMD_NEXT_FLOOR: begin
        if (high_speed_i) begin
          if (in_floor_zone_i && !moving_up_i) begin
            if (current_floor_i != 5'd0) nxt = current_floor_i - 5'd1;
          end else if (moving_up_i) begin
            nxt = (current_floor_i < cfg_i.top_floor) ? current_floor_i + 5'd1
                                                      : cfg_i.top_floor;
          end
          car_d  = floor_bit(nxt);
          down_d = '0;
        end
      end
      CMD_SET_ENABLE: en_d = enable_value_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_q  <= '0;
      down_q <= '0;
      up_q   <= '0;
      idle_q <= '0;
      en_q   <= 1'b0;
    end else if (ctrl_i.step) begin
      car_q  <= car_d;
      down_q <= down_d;
      up_q   <= up_d;
      idle_q <= idle_d;
      en_q   <= en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      reopen_q <= reopen_d;
      light_q  <= light_d;
    end
  end

  assign car_calls_o     = car_q;
  assign down_calls_o    = down_q;
  assign up_calls_o      = up_q;
  assign calls_pending_o = |(car_q | down_q | up_q);
  assign reopen_door_o   = reopen_q;
  assign light_reset_o   = light_q;

endmodule

// File: tb/sv/lcr_checker.sv
module lcr_checker
  import lcr_pkg::*;
#(
  parameter int FLOORS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port, observed only
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  // command channel
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [4:0]  floor_i,
  input  logic [4:0]  current_floor_i,
  input  logic [31:0] car_buttons_i,
  input  logic [31:0] down_buttons_i,
  input  logic [31:0] up_buttons_i,
  input  logic        service_off_i,
  input  logic        moving_up_i,
  input  logic        in_floor_zone_i,
  input  logic        car_idle_i,
  input  logic        high_speed_i,
  input  logic        enable_value_i,
  // status channel
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] car_calls_i,
  input  logic [31:0] down_calls_i,
  input  logic [31:0] up_calls_i,
  input  logic        calls_pending_i,
  input  logic        reopen_door_i,
  input  logic        light_reset_i,
  // to the testbench top
  output int unsigned errors_o,
  output int unsigned outstanding_o
);

  localparam logic [31:0] ALL_FLOORS = 32'((64'd1 << FLOORS) - 64'd1);

  typedef struct packed {
    logic [31:0] car;
    logic [31:0] down;
    logic [31:0] up;
    logic        pending;
    logic        reopen;
    logic        light;
  } call_status_t;

  // register copy
  logic [4:0]  top_fl     = TOP_FLOOR_RST;
  logic [15:0] park_ticks = PARKING_TICKS_RST;
  logic [4:0]  park_fl    = PARK_FLOOR_RST;
  logic        full_coll  = FULL_COLLECTIVE_RST;

  // call state copy
  logic [31:0] car_m    = '0;
  logic [31:0] down_m   = '0;
  logic [31:0] up_m     = '0;
  logic [15:0] idle_cnt = '0;
  logic        scan_en  = 1'b0;

  call_status_t status_q[$];
  int unsigned  mismatches = 0;

  function automatic logic [31:0] floor_bit(input logic [4:0] f);
    if (int'(f) >= FLOORS) return '0;
    return 32'd1 << f;
  endfunction

  // Applies one command to the call state and returns the status it leaves.
  function automatic call_status_t register_command(
    input logic [2:0]  cmd,
    input logic [4:0]  fl,
    input logic [4:0]  cf,
    input logic [31:0] cb,
    input logic [31:0] db,
    input logic [31:0] ub,
    input logic        off,
    input logic        up,
    input logic        zone,
    input logic        idle,
    input logic        hspd,
    input logic        env
  );
    call_status_t r;
    logic [31:0]  served, here, fb, c, d, u, dblock, ublock, rest;
    logic [4:0]   n;
    logic         reopen, light;
    served = 32'((64'd2 << top_fl) - 64'd1) & ALL_FLOORS;
    here   = floor_bit(cf);
    fb     = floor_bit(fl);
    reopen = 1'b0;
    light  = 1'b0;
    case (cmd)
      CMD_SCAN: begin
        if ((car_m | down_m | up_m) != '0) light = 1'b1;
        if (!off) begin
          c = cb & served;
          d = db & served;
          u = full_coll ? (ub & served) : '0;
          if ((c | d | u) != '0) light = 1'b1;
          if (scan_en) begin
            car_m |= c & ~here;
            if (!full_coll) begin
              down_m |= d & ~here;
              if ((d & here) != '0) reopen = 1'b1;
            end else begin
              // no down call at the bottom, no up call at the top
              dblock = here | floor_bit(5'd0);
              ublock = here | floor_bit(top_fl);
              down_m |= d & ~dblock;
              up_m   |= u & ~ublock;
              if (((d & dblock) | (u & ublock)) != '0) reopen = 1'b1;
            end
            if (park_ticks != '0) begin
              if ((car_m | down_m | up_m) != '0) begin
                idle_cnt = '0;
              end else begin
                idle_cnt = idle_cnt + 16'd1;
                if (idle_cnt >= park_ticks) begin
                  idle_cnt = '0;
                  if (cf != park_fl && park_fl <= top_fl && idle) car_m |= floor_bit(park_fl);
                end
              end
            end
          end
        end
      end
      CMD_INSERT: begin
        if (cf != fl && fl <= top_fl) car_m |= fb;
      end
      CMD_DROP_FLOOR: begin
        car_m &= ~fb;
        if (fl == top_fl || fl == 5'd0 || !full_coll) begin
          down_m &= ~fb;
          up_m   &= ~fb;
        end else begin
          // collective clearing: the opposite hall call survives while
          // calls remain further along the travel direction
          rest = car_m | down_m | up_m;
          if (up) begin
            rest &= 32'(64'hFFFF_FFFF << (6'(fl) + 6'd1));
            up_m &= ~fb;
            if (rest == '0) down_m &= ~fb;
          end else begin
            rest &= 32'((64'd1 << fl) - 64'd1);
            down_m &= ~fb;
            if (rest == '0) up_m &= ~fb;
          end
        end
      end
      CMD_DROP_ALL: begin
        car_m  = '0;
        down_m = '0;
        up_m   = '0;
      end
      CMD_NEXT_FLOOR: begin
        if (hspd) begin
          n = cf;
          if (zone && !up) begin
            if (n > 5'd0) n = n - 5'd1;
          end else if (up) begin
            n = (n < top_fl) ? n + 5'd1 : top_fl;
          end
          car_m  = floor_bit(n);
          down_m = '0;
        end
      end
      CMD_SET_ENABLE: scan_en = env;
      default: ;
    endcase
    car_m  &= ALL_FLOORS;
    down_m &= ALL_FLOORS;
    up_m   &= ALL_FLOORS;
    r.car     = car_m;
    r.down    = down_m;
    r.up      = up_m;
    r.pending = (car_m | down_m | up_m) != '0;
    r.reopen  = reopen;
    r.light   = light;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    call_status_t want;
    if (!rst_ni) begin
      top_fl     = TOP_FLOOR_RST;
      park_ticks = PARKING_TICKS_RST;
      park_fl    = PARK_FLOOR_RST;
      full_coll  = FULL_COLLECTIVE_RST;
      car_m      = '0;
      down_m     = '0;
      up_m       = '0;
      idle_cnt   = '0;
      scan_en    = 1'b0;
      status_q.delete();
      errors_o      <= mismatches;
      outstanding_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_TOP_FLOOR:       top_fl     = pwdata[4:0];
          REG_PARKING_TICKS:   park_ticks = pwdata[15:0];
          REG_PARK_FLOOR:      park_fl    = pwdata[4:0];
          REG_FULL_COLLECTIVE: full_coll  = pwdata[0];
          default: ;
        endcase
      end
      // status leaving now belongs to a command taken at an earlier edge
      if (out_valid_i && !out_stall_i) begin
        if (status_q.size() == 0) begin
          $error("status item with no command outstanding");
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("car_calls", want.car, car_calls_i);
          check_field("down_calls", want.down, down_calls_i);
          check_field("up_calls", want.up, up_calls_i);
          check_field("calls_pending", 32'(want.pending), 32'(calls_pending_i));
          check_field("reopen_door", 32'(want.reopen), 32'(reopen_door_i));
          check_field("light_reset", 32'(want.light), 32'(light_reset_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        status_q.push_back(register_command(command_i, floor_i, current_floor_i,
                                            car_buttons_i, down_buttons_i, up_buttons_i,
                                            service_off_i, moving_up_i, in_floor_zone_i,
                                            car_idle_i, high_speed_i, enable_value_i));
      end
      errors_o      <= mismatches;
      outstanding_o <= status_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import lcr_pkg::*;

  localparam int FLOORS        = 32;
  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 6;
  // run limit in clock cycles, kept above the worst legal run
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_ITEMS  = 650;
  localparam int PHASES        = 7;
  localparam int HOLD_CYCLES   = 200;
  // one-stage core: a margin that settles anything still in flight
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_PHASE    = 1;

  // command codes the core has no meaning for; they must leave state alone
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]  cmd;
    logic [4:0]  fl;
    logic [4:0]  cf;
    logic [31:0] cb;
    logic [31:0] db;
    logic [31:0] ub;
    logic        off;
    logic        up;
    logic        zone;
    logic        idle;
    logic        hspd;
    logic        env;
  } call_cmd_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // APB side
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // command item
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [2:0]  command       = '0;
  logic [4:0]  floor_sel     = '0;
  logic [4:0]  current_floor = '0;
  logic [31:0] car_buttons   = '0;
  logic [31:0] down_buttons  = '0;
  logic [31:0] up_buttons    = '0;
  logic        service_off   = 1'b0;
  logic        moving_up     = 1'b0;
  logic        in_floor_zone = 1'b0;
  logic        car_idle      = 1'b0;
  logic        high_speed    = 1'b0;
  logic        enable_value  = 1'b0;

  // status item
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] car_calls;
  logic [31:0] down_calls;
  logic [31:0] up_calls;
  logic        calls_pending;
  logic        reopen_door;
  logic        light_reset;

  int unsigned chk_errors;
  int unsigned outstanding;

  // idling knobs, set per phase by the stimulus
  int unsigned gap_pct   = 20;
  int unsigned stall_pct = 20;
  bit          hold_req  = 1'b0;

  // top floor currently programmed, so floors land mostly in the served range
  logic [4:0]  cur_top   = TOP_FLOOR_RST;
  int unsigned sent      = 0;

  always #(HALF_PERIOD) clk = ~clk;

  lift_call_register_core #(
    .FLOORS(FLOORS)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .floor_i        (floor_sel),
    .current_floor_i(current_floor),
    .car_buttons_i  (car_buttons),
    .down_buttons_i (down_buttons),
    .up_buttons_i   (up_buttons),
    .service_off_i  (service_off),
    .moving_up_i    (moving_up),
    .in_floor_zone_i(in_floor_zone),
    .car_idle_i     (car_idle),
    .high_speed_i   (high_speed),
    .enable_value_i (enable_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .car_calls_o    (car_calls),
    .down_calls_o   (down_calls),
    .up_calls_o     (up_calls),
    .calls_pending_o(calls_pending),
    .reopen_door_o  (reopen_door),
    .light_reset_o  (light_reset)
  );

  lcr_checker #(
    .FLOORS(FLOORS)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .floor_i        (floor_sel),
    .current_floor_i(current_floor),
    .car_buttons_i  (car_buttons),
    .down_buttons_i (down_buttons),
    .up_buttons_i   (up_buttons),
    .service_off_i  (service_off),
    .moving_up_i    (moving_up),
    .in_floor_zone_i(in_floor_zone),
    .car_idle_i     (car_idle),
    .high_speed_i   (high_speed),
    .enable_value_i (enable_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .car_calls_i    (car_calls),
    .down_calls_i   (down_calls),
    .up_calls_i     (up_calls),
    .calls_pending_i(calls_pending),
    .reopen_door_i  (reopen_door),
    .light_reset_i  (light_reset),
    .errors_o       (chk_errors),
    .outstanding_o  (outstanding)
  );

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  // Mostly a served floor, sometimes anything up to 31 (above top is legal).
  function automatic logic [4:0] pick_floor();
    if ($urandom_range(0, 3) != 0) return 5'($urandom_range(0, cur_top));
    return 5'($urandom);
  endfunction

  // Button masks are sparse most of the time so calls do not saturate;
  // all-ones and dense random masks still show up.
  function automatic logic [31:0] sparse_mask();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return '0;
    if (sel < 75) return 32'd1 << pick_floor();
    if (sel < 90) return $urandom & $urandom & $urandom;
    if (sel < 95) return '1;
    return $urandom;
  endfunction

  function automatic call_cmd_t blank(input logic [2:0] cmd);
    call_cmd_t c;
    c.cmd  = cmd;
    c.fl   = '0;
    c.cf   = '0;
    c.cb   = '0;
    c.db   = '0;
    c.ub   = '0;
    c.off  = 1'b0;
    c.up   = 1'b0;
    c.zone = 1'b0;
    c.idle = 1'b0;
    c.hspd = 1'b0;
    c.env  = 1'b0;
    return c;
  endfunction

  // noisy: every field but the command uniform over its full width
  function automatic call_cmd_t make_cmd(input logic [2:0] cmd, input bit noisy);
    call_cmd_t c;
    c.cmd  = cmd;
    c.fl   = noisy ? 5'($urandom) : pick_floor();
    c.cf   = noisy ? 5'($urandom) : pick_floor();
    c.cb   = noisy ? $urandom : sparse_mask();
    c.db   = noisy ? $urandom : sparse_mask();
    c.ub   = noisy ? $urandom : sparse_mask();
    c.off  = noisy ? 1'($urandom) : ($urandom_range(0, 9) == 0);
    c.up   = 1'($urandom);
    c.zone = 1'($urandom);
    c.idle = noisy ? 1'($urandom) : ($urandom_range(0, 3) != 0);
    c.hspd = noisy ? 1'($urandom) : ($urandom_range(0, 3) != 0);
    c.env  = noisy ? 1'($urandom) : ($urandom_range(0, 4) != 0);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one item and holds it until the core takes it. Called right after
  // a rising edge. A sender gap, if drawn, drops valid after the accept.
  task automatic send(input call_cmd_t c);
    in_valid      <= 1'b1;
    command       <= c.cmd;
    floor_sel     <= c.fl;
    current_floor <= c.cf;
    car_buttons   <= c.cb;
    down_buttons  <= c.db;
    up_buttons    <= c.ub;
    service_off   <= c.off;
    moving_up     <= c.up;
    in_floor_zone <= c.zone;
    car_idle      <= c.idle;
    high_speed    <= c.hspd;
    enable_value  <= c.env;
    do @(posedge clk); while (in_stall);
    sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Waits until every taken command has produced its status, plus a margin.
  // Valid must already be low.
  task automatic drain();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup then access cycle, then idle with psel low so back-to-back writes
  // never assign psel twice in one step.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] top, input logic [15:0] ticks,
                            input logic [4:0] pfl, input logic fc);
    write_reg(REG_TOP_FLOOR, 32'(top));
    write_reg(REG_PARKING_TICKS, 32'(ticks));
    write_reg(REG_PARK_FLOOR, 32'(pfl));
    write_reg(REG_FULL_COLLECTIVE, 32'(fc));
    cur_top = top;
  endtask

  // ---------------------------------------------------------------------------
  // Status receiver: random stall bursts, plus one long hold-off on request so
  // the result register fills and the command side backs up.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned burst;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Run limit, independent of the stimulus.
  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("lift_call_register_core regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    call_cmd_t   c;
    int unsigned target, r, k, ph;
    logic [4:0]  f;
    logic [2:0]  cmd;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: full collective, top floor 7, parking after two idle
    // scans to floor 3.
    set_config(5'd7, 16'd2, 5'd3, 1'b1);

    // presses before scanning is enabled only raise the light reset flag
    c = blank(CMD_SCAN);
    c.cb = '1; c.db = '1; c.ub = '1; c.cf = 5'd2;
    send(c);
    send(make_cmd(CMD_SPARE_6, 1'b1));
    c = blank(CMD_SET_ENABLE); c.env = 1'b1;
    send(c);
    // out of service suppresses everything
    c = blank(CMD_SCAN);
    c.cb = '1; c.db = '1; c.ub = '1; c.off = 1'b1;
    send(c);
    // every button at floor 0: presses above top ignored, floor 0 down and
    // top floor up blocked and ask reopen
    c = blank(CMD_SCAN);
    c.cb = '1; c.db = '1; c.ub = '1; c.cf = 5'd0;
    send(c);
    // collective drops, both directions, then the end floors
    c = blank(CMD_DROP_FLOOR); c.fl = 5'd3; c.up = 1'b1;
    send(c);
    c = blank(CMD_DROP_FLOOR); c.fl = 5'd5; c.up = 1'b0;
    send(c);
    c = blank(CMD_DROP_FLOOR); c.fl = 5'd7;
    send(c);
    c = blank(CMD_DROP_FLOOR); c.fl = 5'd0;
    send(c);
    // inserts: at current floor, above top, and exactly at top
    c = blank(CMD_INSERT); c.fl = 5'd4; c.cf = 5'd4;
    send(c);
    c = blank(CMD_INSERT); c.fl = 5'd8; c.cf = 5'd0;
    send(c);
    c = blank(CMD_INSERT); c.fl = 5'd7; c.cf = 5'd0;
    send(c);
    // next floor: low speed does nothing; clamps at bottom and top; out of
    // zone going down keeps the current floor; above top clamps to top
    c = blank(CMD_NEXT_FLOOR); c.cf = 5'd3;
    send(c);
    c = blank(CMD_NEXT_FLOOR); c.hspd = 1'b1; c.zone = 1'b1; c.cf = 5'd0;
    send(c);
    c = blank(CMD_NEXT_FLOOR); c.hspd = 1'b1; c.up = 1'b1; c.cf = 5'd7;
    send(c);
    c = blank(CMD_NEXT_FLOOR); c.hspd = 1'b1; c.cf = 5'd5;
    send(c);
    c = blank(CMD_NEXT_FLOOR); c.hspd = 1'b1; c.up = 1'b1; c.cf = 5'd20;
    send(c);
    // parking fires on the second idle scan
    send(blank(CMD_DROP_ALL));
    repeat (2) begin
      c = blank(CMD_SCAN); c.idle = 1'b1;
      send(c);
    end
    // car already at the parking floor: no call
    send(blank(CMD_DROP_ALL));
    repeat (2) begin
      c = blank(CMD_SCAN); c.idle = 1'b1; c.cf = 5'd3;
      send(c);
    end
    send(make_cmd(CMD_SPARE_7, 1'b1));
    send(blank(CMD_SET_ENABLE));
    in_valid <= 1'b0;
    drain();

    // Random part: one register setting per phase, extremes included.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin set_config(5'd31, 16'd0, 5'd0, 1'b0); gap_pct = 20; stall_pct = 20; end
        1: begin set_config(5'd7, 16'd3, 5'd5, 1'b1); gap_pct = 15; stall_pct = 15; end
        2: begin set_config(5'd0, 16'd1, 5'd0, 1'b1); gap_pct = 30; stall_pct = 0; end
        3: begin set_config(5'd31, 16'hFFFF, 5'd31, 1'b1); gap_pct = 0; stall_pct = 30; end
        // parking floor above top: never parks
        4: begin set_config(5'd4, 16'd2, 5'd9, 1'b0); gap_pct = 10; stall_pct = 10; end
        5: begin
          set_config(5'($urandom), 16'($urandom_range(1, 6)), 5'($urandom), 1'($urandom));
          gap_pct = 25; stall_pct = 25;
        end
        // closing phase runs with no idling on either side
        default: begin set_config(5'd12, 16'd4, 5'd2, 1'b1); gap_pct = 0; stall_pct = 0; end
      endcase
      if (ph == HOLD_PHASE) hold_req = 1'b1;

      c = blank(CMD_SET_ENABLE); c.env = 1'b1;
      send(c);
      target = sent + RANDOM_ITEMS / PHASES;
      while (sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          // one plain command
          r = $urandom_range(0, 99);
          if (r < 40)      cmd = CMD_SCAN;
          else if (r < 55) cmd = CMD_INSERT;
          else if (r < 70) cmd = CMD_DROP_FLOOR;
          else if (r < 75) cmd = CMD_DROP_ALL;
          else if (r < 88) cmd = CMD_NEXT_FLOOR;
          else if (r < 97) cmd = CMD_SET_ENABLE;
          else if (r < 98) cmd = CMD_SPARE_6;
          else             cmd = CMD_SPARE_7;
          send(make_cmd(cmd, 1'b0));
        end else if (r < 75) begin
          // trip: press, extra car call, approach at speed, stop at the floor
          f = pick_floor();
          c = make_cmd(CMD_SCAN, 1'b0); c.off = 1'b0; c.cb = 32'd1 << f;
          send(c);
          send(make_cmd(CMD_INSERT, 1'b0));
          c = make_cmd(CMD_NEXT_FLOOR, 1'b0); c.hspd = 1'b1;
          send(c);
          c = make_cmd(CMD_DROP_FLOOR, 1'b0); c.fl = f;
          send(c);
        end else if (r < 90) begin
          // idle stretch: cleared calls and empty scans drive the parking timer
          c = blank(CMD_SET_ENABLE); c.env = 1'b1;
          send(c);
          send(blank(CMD_DROP_ALL));
          k = $urandom_range(1, 8);
          repeat (k) begin
            c = blank(CMD_SCAN);
            c.cf   = pick_floor();
            c.fl   = 5'($urandom);
            c.idle = ($urandom_range(0, 4) != 0);
            c.up   = 1'($urandom);
            send(c);
          end
        end else begin
          cmd = 3'($urandom_range(0, 7));
          send(make_cmd(cmd, 1'b1));
        end
      end
      // sender pauses until every status item is back before reprogramming
      in_valid <= 1'b0;
      drain();
    end

    if (chk_errors == 0 && outstanding == 0) begin
      $display("lift_call_register_core regression: pass");
    end else begin
      $display("lift_call_register_core regression: fail");
    end
    $finish;
  end

endmodule
